FILE: sv/hexp_pkg.sv
// shared types, codes and character helpers for the hex text parser
package hexp_pkg;

  // input word kinds
  typedef enum logic [0:0] {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_e;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_STRAY_END = 2'd2,
    KIND_BAD_TOKEN = 2'd3
  } kind_e;

  localparam int unsigned CharBits   = 8;
  localparam int unsigned OutCntBits = 32;
  localparam int unsigned OutDataW   = 48;  // byte, count, error flag, padded
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  localparam logic [CharBits-1:0] ChSlash = 8'h2F;
  localparam logic [CharBits-1:0] ChStar  = 8'h2A;

  // one input word after the handshake
  typedef struct packed {
    op_e                 op;
    logic [CharBits-1:0] char_code;
  } item_t;

  // one result word
  typedef struct packed {
    kind_e                 kind;
    logic [CharBits-1:0]   byte_value;
    logic [OutCntBits-1:0] byte_count;
    logic                  had_error;
    logic                  last_of_run;
  } res_t;

  // space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [CharBits-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_hex(input logic [CharBits-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // nibble value of a hex digit, zero for anything else
  function automatic logic [3:0] hex_nibble(input logic [CharBits-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

FILE: sv/hexp_core.sv
// token tracking, comment nesting and result generation for one word per cycle
module hexp_core
  import hexp_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic [1:0]  res_cnt_o,
  output res_t        res_o [2]
);

  logic [1:0]            tok_len_q, tok_len_d;
  logic [CharBits-1:0]   first_q, first_d;
  logic [CharBits-1:0]   second_q, second_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic                  err_q, err_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                  finish;
  logic                  tok_live;
  logic                  tok_data;
  logic [COUNT_BITS-1:0] cnt_tok;
  logic                  tok_emit;
  res_t                  tok_res;
  logic [OutCntBits-1:0] cnt_out;
  res_t                  done_res;

  // token end and a pending token that still counts
  assign finish   = valid_i && ((item_i.op == OP_END) ||
                                (!err_q && is_space(item_i.char_code)));
  assign tok_live = (tok_len_q != 2'd0) && !err_q;
  assign tok_data = finish && tok_live && (depth_q == '0) && (tok_len_q == 2'd2) &&
                    is_hex(first_q) && is_hex(second_q);

  // byte count including a byte from the closing token
  always_comb begin
    cnt_tok = cnt_q;
    if (tok_data && !(&cnt_q)) begin
      cnt_tok = cnt_q + 1'b1;
    end
  end

  // byte count seen on the result port, held at all ones past 32 bits
  if (COUNT_BITS > OutCntBits) begin : g_cnt_wide
    assign cnt_out = (|cnt_tok[COUNT_BITS-1:OutCntBits]) ? '1 : cnt_tok[OutCntBits-1:0];
  end else if (COUNT_BITS == OutCntBits) begin : g_cnt_same
    assign cnt_out = cnt_tok;
  end else begin : g_cnt_narrow
    assign cnt_out = {{(OutCntBits-COUNT_BITS){1'b0}}, cnt_tok};
  end

  // next state and results
  always_comb begin
    tok_len_d = tok_len_q;
    first_d   = first_q;
    second_d  = second_q;
    depth_d   = depth_q;
    err_d     = err_q;
    cnt_d     = cnt_tok;
    tok_emit  = 1'b0;
    tok_res   = '0;

    // close the pending token
    if (finish) begin
      tok_len_d = 2'd0;
      if (tok_live) begin
        if (tok_len_q == 2'd2 && first_q == ChSlash && second_q == ChStar) begin
          if (!(&depth_q)) begin
            depth_d = depth_q + 1'b1;
          end
        end else if (tok_len_q == 2'd2 && first_q == ChStar && second_q == ChSlash) begin
          if (depth_q == '0) begin
            err_d             = 1'b1;
            tok_emit          = 1'b1;
            tok_res.kind      = KIND_STRAY_END;
            tok_res.had_error = 1'b1;
          end else begin
            depth_d = depth_q - 1'b1;
          end
        end else if (depth_q == '0) begin
          tok_emit = 1'b1;
          if (tok_len_q == 2'd2 && is_hex(first_q) && is_hex(second_q)) begin
            tok_res.kind       = KIND_DATA;
            tok_res.byte_value = {hex_nibble(first_q), hex_nibble(second_q)};
          end else begin
            err_d             = 1'b1;
            tok_res.kind      = KIND_BAD_TOKEN;
            tok_res.had_error = 1'b1;
          end
        end
      end
    end

    // grow the token on any non-space character while no error is set
    if (valid_i && item_i.op == OP_CHAR && !err_q && !is_space(item_i.char_code)) begin
      if (tok_len_q == 2'd0) begin
        first_d = item_i.char_code;
      end else if (tok_len_q == 2'd1) begin
        second_d = item_i.char_code;
      end
      if (tok_len_q != 2'd3) begin
        tok_len_d = tok_len_q + 2'd1;
      end
    end

    tok_res.byte_count = cnt_out;

    done_res            = '0;
    done_res.kind       = KIND_DONE;
    done_res.byte_count = cnt_out;
    done_res.had_error  = err_d;
    done_res.last_of_run = 1'b1;

    // pack the results, the last one flagged
    res_o[0]  = '0;
    res_o[1]  = '0;
    res_cnt_o = 2'd0;
    if (valid_i && item_i.op == OP_END) begin
      if (tok_emit) begin
        res_o[0]  = tok_res;
        res_o[1]  = done_res;
        res_cnt_o = 2'd2;
      end else begin
        res_o[0]  = done_res;
        res_cnt_o = 2'd1;
      end
      // end of stream clears everything
      tok_len_d = 2'd0;
      first_d   = '0;
      second_d  = '0;
      depth_d   = '0;
      err_d     = 1'b0;
      cnt_d     = '0;
    end else if (tok_emit) begin
      res_o[0]             = tok_res;
      res_o[0].last_of_run = 1'b1;
      res_cnt_o            = 2'd1;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_len_q <= 2'd0;
      first_q   <= '0;
      second_q  <= '0;
      depth_q   <= '0;
      err_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      tok_len_q <= tok_len_d;
      first_q   <= first_d;
      second_q  <= second_d;
      depth_q   <= depth_d;
      err_q     <= err_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

FILE: sv/hexp_outq.sv
// small result queue taking up to two words per cycle and giving one
module hexp_outq
  import hexp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  res_t       push_i [2],
  input  logic       pop_i,
  output logic       room2_o,
  output logic       valid_o,
  output res_t       head_o
);

  res_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic [QueuePtrW-1:0] wr_ptr_nx;
  logic                 do_pop;

  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign do_pop    = pop_i && (cnt_q != '0);
  assign valid_o   = (cnt_q != '0);
  assign head_o    = mem_q[rd_ptr_q];
  assign room2_o   = (cnt_q <= QueueCntW'(QueueDepth - 2));

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + QueuePtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + QueuePtrW'(do_pop);
    cnt_d    = cnt_q + QueueCntW'(push_cnt_i) - QueueCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i[1];
    end
  end

endmodule

FILE: sv/hex_text_to_bytes_parser.sv
// hex text to byte stream parser, top level
//
// channel  dir  tdata                                        tuser      tlast
// s_axis   in   [7:0] char_code                              [0] op     -
// m_axis   out  [7:0] byte_value, [39:8] byte_count,         [1:0] kind last_of_run
//               [40] had_error, [47:41] zero
//
// one input word per cycle while s_axis_tready is high; each word is held in the input
// register and is parsed into the result queue when the queue has two free entries
// an end word whose pending token yields a result gives two results
// s_axis_tready drops while a word waits in the input register and the result
// queue has fewer than two free entries
// reset clears all parser state and the queue; no clearing pass is needed
module hex_text_to_bytes_parser
  import hexp_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]          s_axis_tuser,   // [0] op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] byte_value, [39:8] byte_count,
                                              // [40] had_error
  output logic [1:0]          m_axis_tuser,   // [1:0] kind
  output logic                m_axis_tlast    // last_of_run
);

  logic       in_vld_q;
  item_t      in_item_q;
  logic       advance;
  logic       room2;
  logic [1:0] res_cnt;
  res_t       res [2];
  logic       q_valid;
  res_t       q_head;

  assign advance       = in_vld_q && room2;
  assign s_axis_tready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= item_t'{op: op_e'(s_axis_tuser[0]), char_code: s_axis_tdata};
    end
  end

  hexp_core #(
    .DEPTH_BITS(DEPTH_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (advance),
    .item_i   (in_item_q),
    .res_cnt_o(res_cnt),
    .res_o    (res)
  );

  hexp_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(res_cnt),
    .push_i    (res),
    .pop_i     (m_axis_tready),
    .room2_o   (room2),
    .valid_o   (q_valid),
    .head_o    (q_head)
  );

  // result word from the queue head
  assign m_axis_tvalid = q_valid;
  assign m_axis_tuser  = q_head.kind;
  assign m_axis_tlast  = q_head.last_of_run;
  assign m_axis_tdata  = {{(OutDataW - CharBits - OutCntBits - 1){1'b0}},
                          q_head.had_error, q_head.byte_count, q_head.byte_value};

endmodule

FILE: sv/hexp_chk.sv
// port checker for the hex text parser, bound to the top level
module hexp_chk
  import hexp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  // a stalled result word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // data bytes never carry the error flag
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_DATA) |-> !m_axis_tdata[40])
    else $error("data byte flagged as error");

  // error words carry the flag and a zero byte
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_STRAY_END || m_axis_tuser == KIND_BAD_TOKEN))
    |-> (m_axis_tdata[40] && m_axis_tdata[7:0] == 8'h00))
    else $error("malformed error word");

  // a done word always closes the run of its input word
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
    else $error("done word not marked last");

endmodule

bind hex_text_to_bytes_parser hexp_chk u_hexp_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

FILE: sim/hexp_stream_checker.sv
// stream checker for the hex text parser: predicts result words and compares them
`timescale 1ns / 100ps

module hexp_stream_checker
  import hexp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          in_data_i,    // [7:0] char_code
  input  logic [0:0]          in_user_i,    // [0] op
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OutDataW-1:0] out_data_i,   // [7:0] byte_value, [39:8] byte_count,
                                            // [40] had_error
  input  logic [1:0]          out_user_i,   // [1:0] kind
  input  logic                out_last_i,   // last_of_run
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int unsigned DepthBits  = 8;
  localparam int unsigned CountBits  = 32;
  localparam int          MaxReports = 200;

  // predicted parser state
  logic [1:0]           tok_len;
  logic [7:0]           tok_c0;
  logic [7:0]           tok_c1;
  logic [DepthBits-1:0] nest;
  bit                   aborted;
  logic [CountBits-1:0] n_bytes;

  res_t expected_words[$];
  int   mismatches;
  int   checked;

  assign fail_count_o = mismatches;
  assign checked_o    = checked;

  function automatic void clear_parser();
    tok_len = '0;
    tok_c0  = '0;
    tok_c1  = '0;
    nest    = '0;
    aborted = 1'b0;
    n_bytes = '0;
  endfunction

  // value of a hex digit in either case, -1 for anything else
  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [OutCntBits-1:0] reported_count();
    if (n_bytes > {OutCntBits{1'b1}}) return '1;
    return n_bytes[OutCntBits-1:0];
  endfunction

  // end of a token: comment markers, data byte or bad token
  function automatic bit close_token(output res_t r);
    logic [1:0] len;
    int         hi;
    int         lo;
    len     = tok_len;
    tok_len = '0;
    r       = '0;
    if (len == 2'd0 || aborted) return 1'b0;
    if (len == 2'd2 && tok_c0 == ChSlash && tok_c1 == ChStar) begin
      if (nest != '1) nest = nest + 1'b1;
      return 1'b0;
    end
    if (len == 2'd2 && tok_c0 == ChStar && tok_c1 == ChSlash) begin
      if (nest == '0) begin
        aborted      = 1'b1;
        r.kind       = KIND_STRAY_END;
        r.had_error  = 1'b1;
        r.byte_count = reported_count();
        return 1'b1;
      end
      nest = nest - 1'b1;
      return 1'b0;
    end
    // anything else inside a comment is skipped
    if (nest != '0) return 1'b0;
    hi = digit_value(tok_c0);
    lo = digit_value(tok_c1);
    if (len != 2'd2 || hi < 0 || lo < 0) begin
      aborted      = 1'b1;
      r.kind       = KIND_BAD_TOKEN;
      r.had_error  = 1'b1;
      r.byte_count = reported_count();
      return 1'b1;
    end
    if (n_bytes != '1) n_bytes = n_bytes + 1'b1;
    r.kind       = KIND_DATA;
    r.byte_value = 8'(hi * 16 + lo);
    r.byte_count = reported_count();
    return 1'b1;
  endfunction

  // results caused by one accepted input word
  function automatic void predict_word(input item_t w);
    res_t r;
    res_t batch[$];
    if (w.op == OP_CHAR) begin
      if (aborted) return;
      if (w.char_code == 8'h20 || (w.char_code >= 8'h09 && w.char_code <= 8'h0D)) begin
        if (close_token(r)) batch.push_back(r);
      end else begin
        if (tok_len == 2'd0) tok_c0 = w.char_code;
        else if (tok_len == 2'd1) tok_c1 = w.char_code;
        if (tok_len != 2'd3) tok_len = tok_len + 1'b1;
      end
    end else begin
      if (close_token(r)) batch.push_back(r);
      r            = '0;
      r.kind       = KIND_DONE;
      r.had_error  = aborted;
      r.byte_count = reported_count();
      batch.push_back(r);
      clear_parser();
    end
    if (batch.size() > 0) batch[batch.size()-1].last_of_run = 1'b1;
    foreach (batch[i]) expected_words.push_back(batch[i]);
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // compare finished words first, then predict from the accepted input word
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    res_t  want;
    item_t word;
    if (!rst_ni) begin
      expected_words.delete();
      clear_parser();
      mismatches = 0;
      checked    = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $error("result word with nothing expected: kind %0d", out_user_i);
        end else begin
          want = expected_words.pop_front();
          check_field("kind", want.kind, out_user_i);
          check_field("byte_value", want.byte_value, out_data_i[7:0]);
          check_field("byte_count", want.byte_count, out_data_i[39:8]);
          check_field("had_error", want.had_error, out_data_i[40]);
          check_field("last_of_run", want.last_of_run, out_last_i);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        word.op        = op_e'(in_user_i[0]);
        word.char_code = in_data_i;
        predict_word(word);
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// top of the hex text parser bench: clock, reset, text stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import hexp_pkg::*;

  localparam int RandomWords = 200;
  localparam int CycleLimit  = 500_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;    // [7:0] char_code
  logic [0:0]          s_axis_tuser;    // [0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;    // [7:0] byte_value, [39:8] byte_count,
                                        // [40] had_error
  logic [1:0]          m_axis_tuser;    // [1:0] kind
  logic                m_axis_tlast;    // last_of_run

  int mismatches;
  int pending;
  int checked;
  int words_sent   = 0;
  int streams_sent = 0;
  int cycles       = 0;
  bit idle_on      = 1'b1;

  string hex_digits = "0123456789abcdefABCDEF";

  hex_text_to_bytes_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hexp_stream_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .out_last_i   (m_axis_tlast),
    .fail_count_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stall bursts while idling is on
  initial begin : rx_side
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one word over the input channel, with an optional gap in front
  task automatic send_word(input op_e op, input logic [7:0] code);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic feed_text(input string s);
    for (int k = 0; k < s.len(); k++) send_word(OP_CHAR, s[k]);
  endtask

  task automatic close_stream();
    send_word(OP_END, 8'($urandom_range(0, 255)));
    streams_sent++;
  endtask

  // one or two separators of the six whitespace kinds
  task automatic feed_gap();
    int n;
    int sel;
    n = $urandom_range(1, 2);
    repeat (n) begin
      sel = $urandom_range(0, 5);
      send_word(OP_CHAR, (sel == 5) ? 8'h20 : 8'(8'h09 + sel));
    end
  endtask

  task automatic feed_hex_pair();
    send_word(OP_CHAR, hex_digits[$urandom_range(0, 21)]);
    send_word(OP_CHAR, hex_digits[$urandom_range(0, 21)]);
  endtask

  // bad tokens: random bytes, or hex digit runs of the wrong length
  task automatic feed_junk();
    int n;
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 1) == 0) begin
      repeat (n) send_word(OP_CHAR, 8'($urandom_range(0, 255)));
    end else begin
      repeat ((n > 2) ? 3 : 1) send_word(OP_CHAR, hex_digits[$urandom_range(0, 21)]);
    end
  endtask

  // mostly well formed text; noisy streams add bad tokens and stray closers
  task automatic feed_random_stream();
    int n_tok;
    int sel;
    int open_depth;
    bit noisy;
    n_tok      = $urandom_range(1, 10);
    noisy      = ($urandom_range(0, 4) == 0);
    open_depth = 0;
    for (int t = 0; t < n_tok; t++) begin
      if (t > 0 || $urandom_range(0, 3) == 0) feed_gap();
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        feed_text("/*");
        open_depth++;
      end else if (sel < 20 && (open_depth > 0 || noisy)) begin
        feed_text("*/");
        if (open_depth > 0) open_depth--;
      end else if (noisy && sel < 45) begin
        feed_junk();
      end else begin
        feed_hex_pair();
      end
    end
    // leaving the last token open lets the end word give two results
    if ($urandom_range(0, 1) == 0) feed_gap();
    close_stream();
  endtask

  // hold the sender until every predicted word has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int random_start;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bare separator, both digit cases, a comment with a 0xFF inside,
    // a NUL token closed by the end word, stray closer, text after the error,
    // and an empty stream
    feed_text(" 0f");
    send_word(OP_CHAR, 8'h09);
    feed_text("A9");
    send_word(OP_CHAR, 8'h0A);
    feed_text("/*");
    send_word(OP_CHAR, 8'h0B);
    send_word(OP_CHAR, 8'hFF);
    send_word(OP_CHAR, 8'h0C);
    feed_text("*/");
    send_word(OP_CHAR, 8'h0D);
    send_word(OP_CHAR, 8'h00);
    close_stream();
    feed_text("*/ b ");
    close_stream();
    close_stream();
    drain_results();

    // nesting past the depth limit: the depth holds at its maximum, so one
    // closer still leaves the bytes after it inside a comment
    for (int i = 0; i < 256; i++) begin
      feed_text("/* ");
      if (i % 64 == 63) feed_text("zz 123 ");
    end
    feed_text("*/ aa 55 ");
    close_stream();
    drain_results();

    // random streams; the tail runs without idling
    random_start = words_sent;
    while (words_sent - random_start < RandomWords) begin
      if (words_sent - random_start > RandomWords - 60) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      feed_random_stream();
      if ($urandom_range(0, 11) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words in %0d streams, compared %0d result words.",
             words_sent, streams_sent, checked);
    $display("Covered hex pairs, comments nested to the limit, stray closers and bad tokens.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
